@@ rtl/core/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// Types and codes shared by the 128-bit range compare and cut pipeline.
// ----------------------------------------------------------------------------
package rrc_pkg;

	typedef logic [127:0] addr_t;

	localparam logic [2:0] REL_EQUAL    = 3'd0;
	localparam logic [2:0] REL_INSIDE   = 3'd1;
	localparam logic [2:0] REL_ENCLOSES = 3'd2;
	localparam logic [2:0] REL_OVL_LOW  = 3'd3;
	localparam logic [2:0] REL_BELOW    = 3'd4;
	localparam logic [2:0] REL_OVL_HIGH = 3'd5;
	localparam logic [2:0] REL_ABOVE    = 3'd6;
	localparam logic [2:0] REL_ERROR    = 3'd7;

	typedef struct packed {
		logic [63:0] a_low_upper;
		logic [63:0] a_low_lower;
		logic [63:0] a_high_upper;
		logic [63:0] a_high_lower;
		logic [63:0] b_low_upper;
		logic [63:0] b_low_lower;
		logic [63:0] b_high_upper;
		logic [63:0] b_high_lower;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  relation;
		logic [1:0]  piece_index;
		logic        piece_valid;
		logic [63:0] piece_low_upper;
		logic [63:0] piece_low_lower;
		logic [63:0] piece_high_upper;
		logic [63:0] piece_high_lower;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic hi_eq;
		logic hi_lt;
		logic hi_gt;
		logic lo_eq;
		logic lo_lt;
		logic lo_gt;
	} cmp_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        c;
	} step_t;

	typedef struct packed {
		addr_t a1;
		addr_t a2;
		addr_t b1;
		addr_t b2;
		cmp_t  c11;
		cmp_t  c22;
		cmp_t  c12;
		cmp_t  c21;
		step_t da1;
		step_t db1;
		step_t ia2;
		step_t ib2;
	} s1_t;

	typedef struct packed {
		logic [2:0] rel;
		logic       eq_low;
		logic       eq_high;
		addr_t      a1;
		addr_t      a2;
		addr_t      b1;
		addr_t      b2;
		addr_t      dec_a1;
		addr_t      dec_b1;
		addr_t      inc_a2;
		addr_t      inc_b2;
	} s2_t;

	typedef struct packed {
		addr_t lo;
		addr_t hi;
	} piece_t;

	typedef struct packed {
		logic [2:0]       rel;
		logic             has_piece;
		logic [1:0]       cnt;
		piece_t [2:0]     pc;
	} s3_t;

endpackage

@@ rtl/core/rrc_cmp.sv @@
// ----------------------------------------------------------------------------
// rrc_cmp
// First stage: 64-bit half compares of the endpoint pairs and the lower half
// of each plus or minus one step.
// ----------------------------------------------------------------------------
module rrc_cmp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  rrc_pkg::in_beat_t up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output rrc_pkg::s1_t     dn_data
);

	logic         vld_s1;
	rrc_pkg::s1_t st_s1;
	rrc_pkg::s1_t nxt;

	function automatic rrc_pkg::cmp_t half_cmp(rrc_pkg::addr_t x, rrc_pkg::addr_t y);
		rrc_pkg::cmp_t r;
		r.hi_eq = x[127:64] == y[127:64];
		r.hi_lt = x[127:64] <  y[127:64];
		r.hi_gt = x[127:64] >  y[127:64];
		r.lo_eq = x[63:0] == y[63:0];
		r.lo_lt = x[63:0] <  y[63:0];
		r.lo_gt = x[63:0] >  y[63:0];
		return r;
	endfunction

	function automatic rrc_pkg::step_t low_dec(rrc_pkg::addr_t x);
		rrc_pkg::step_t r;
		r.hi = x[127:64];
		r.lo = x[63:0] - 64'd1;
		r.c  = x[63:0] == 64'd0;
		return r;
	endfunction

	function automatic rrc_pkg::step_t low_inc(rrc_pkg::addr_t x);
		rrc_pkg::step_t r;
		r.hi = x[127:64];
		r.lo = x[63:0] + 64'd1;
		r.c  = x[63:0] == '1;
		return r;
	endfunction

	always_comb begin
		nxt.a1  = {up_data.a_low_upper, up_data.a_low_lower};
		nxt.a2  = {up_data.a_high_upper, up_data.a_high_lower};
		nxt.b1  = {up_data.b_low_upper, up_data.b_low_lower};
		nxt.b2  = {up_data.b_high_upper, up_data.b_high_lower};
		nxt.c11 = half_cmp(nxt.a1, nxt.b1);
		nxt.c22 = half_cmp(nxt.a2, nxt.b2);
		nxt.c12 = half_cmp(nxt.a1, nxt.b2);
		nxt.c21 = half_cmp(nxt.a2, nxt.b1);
		nxt.da1 = low_dec(nxt.a1);
		nxt.db1 = low_dec(nxt.b1);
		nxt.ia2 = low_inc(nxt.a2);
		nxt.ib2 = low_inc(nxt.b2);
	end

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign dn_data  = st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			st_s1 <= nxt;
		end
	end

endmodule

@@ rtl/core/rrc_class.sv @@
// ----------------------------------------------------------------------------
// rrc_class
// Second stage: full 128-bit compares, relation class in priority order and
// the upper half of each plus or minus one step.
// ----------------------------------------------------------------------------
module rrc_class (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  rrc_pkg::s1_t up_data,
	output logic         dn_valid,
	input  logic         dn_ready,
	output rrc_pkg::s2_t dn_data
);

	logic         vld_s2;
	rrc_pkg::s2_t st_s2;
	rrc_pkg::s2_t nxt;
	logic         eq11, eq22, lt11, gt11, lt22, gt22, lt12, gt12, gt21;

	function automatic logic is_lt(rrc_pkg::cmp_t c);
		return c.hi_lt || (c.hi_eq && c.lo_lt);
	endfunction

	function automatic logic is_gt(rrc_pkg::cmp_t c);
		return c.hi_gt || (c.hi_eq && c.lo_gt);
	endfunction

	always_comb begin
		eq11 = up_data.c11.hi_eq && up_data.c11.lo_eq;
		eq22 = up_data.c22.hi_eq && up_data.c22.lo_eq;
		lt11 = is_lt(up_data.c11);
		gt11 = is_gt(up_data.c11);
		lt22 = is_lt(up_data.c22);
		gt22 = is_gt(up_data.c22);
		lt12 = is_lt(up_data.c12);
		gt12 = is_gt(up_data.c12);
		gt21 = is_gt(up_data.c21);

		if (eq11 && eq22) begin
			nxt.rel = rrc_pkg::REL_EQUAL;
		end else if (!lt11 && lt12 && !gt22) begin
			nxt.rel = rrc_pkg::REL_INSIDE;
		end else if (!gt11 && !lt22) begin
			nxt.rel = rrc_pkg::REL_ENCLOSES;
		end else if (lt11 && lt22 && gt21) begin
			nxt.rel = rrc_pkg::REL_OVL_LOW;
		end else if (lt11 && lt22) begin
			nxt.rel = rrc_pkg::REL_BELOW;
		end else if (gt11 && lt12 && gt22) begin
			nxt.rel = rrc_pkg::REL_OVL_HIGH;
		end else if (gt12) begin
			nxt.rel = rrc_pkg::REL_ABOVE;
		end else begin
			nxt.rel = rrc_pkg::REL_ERROR;
		end

		nxt.eq_low  = eq11;
		nxt.eq_high = eq22;
		nxt.a1      = up_data.a1;
		nxt.a2      = up_data.a2;
		nxt.b1      = up_data.b1;
		nxt.b2      = up_data.b2;
		nxt.dec_a1  = {up_data.da1.hi - {63'd0, up_data.da1.c}, up_data.da1.lo};
		nxt.dec_b1  = {up_data.db1.hi - {63'd0, up_data.db1.c}, up_data.db1.lo};
		nxt.inc_a2  = {up_data.ia2.hi + {63'd0, up_data.ia2.c}, up_data.ia2.lo};
		nxt.inc_b2  = {up_data.ib2.hi + {63'd0, up_data.ib2.c}, up_data.ib2.lo};
	end

	assign up_ready = !vld_s2 || dn_ready;
	assign dn_valid = vld_s2;
	assign dn_data  = st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (up_ready) begin
			vld_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			st_s2 <= nxt;
		end
	end

endmodule

@@ rtl/core/rrc_cut.sv @@
// ----------------------------------------------------------------------------
// rrc_cut
// Third stage: picks the cut pieces and their count for the relation class.
// ----------------------------------------------------------------------------
module rrc_cut (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  rrc_pkg::s2_t up_data,
	output logic         dn_valid,
	input  logic         dn_ready,
	output rrc_pkg::s3_t dn_data
);

	logic         vld_s3;
	rrc_pkg::s3_t st_s3;
	rrc_pkg::s3_t nxt;

	always_comb begin
		nxt.rel       = up_data.rel;
		nxt.has_piece = 1'b1;
		nxt.cnt       = 2'd3;
		nxt.pc        = '0;
		case (up_data.rel)
			rrc_pkg::REL_OVL_LOW: begin
				nxt.pc[0] = {up_data.a1, up_data.dec_b1};
				nxt.pc[1] = {up_data.b1, up_data.a2};
				nxt.pc[2] = {up_data.inc_a2, up_data.b2};
			end
			rrc_pkg::REL_OVL_HIGH: begin
				nxt.pc[0] = {up_data.b1, up_data.dec_a1};
				nxt.pc[1] = {up_data.a1, up_data.b2};
				nxt.pc[2] = {up_data.inc_b2, up_data.a2};
			end
			rrc_pkg::REL_INSIDE: begin
				if (up_data.eq_low) begin
					nxt.cnt   = 2'd2;
					nxt.pc[0] = {up_data.a1, up_data.a2};
					nxt.pc[1] = {up_data.inc_a2, up_data.b2};
				end else if (up_data.eq_high) begin
					nxt.cnt   = 2'd2;
					nxt.pc[0] = {up_data.b1, up_data.dec_a1};
					nxt.pc[1] = {up_data.a1, up_data.a2};
				end else begin
					nxt.pc[0] = {up_data.b1, up_data.dec_a1};
					nxt.pc[1] = {up_data.a1, up_data.a2};
					nxt.pc[2] = {up_data.inc_a2, up_data.b2};
				end
			end
			rrc_pkg::REL_ENCLOSES: begin
				if (up_data.eq_low) begin
					nxt.cnt   = 2'd2;
					nxt.pc[0] = {up_data.b1, up_data.b2};
					nxt.pc[1] = {up_data.inc_b2, up_data.a2};
				end else if (up_data.eq_high) begin
					nxt.cnt   = 2'd2;
					nxt.pc[0] = {up_data.a1, up_data.dec_b1};
					nxt.pc[1] = {up_data.b1, up_data.b2};
				end else begin
					nxt.pc[0] = {up_data.a1, up_data.dec_b1};
					nxt.pc[1] = {up_data.b1, up_data.b2};
					nxt.pc[2] = {up_data.inc_b2, up_data.a2};
				end
			end
			default: begin
				nxt.has_piece = 1'b0;
				nxt.cnt       = 2'd1;
			end
		endcase
	end

	assign up_ready = !vld_s3 || dn_ready;
	assign dn_valid = vld_s3;
	assign dn_data  = st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (up_ready) begin
			vld_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			st_s3 <= nxt;
		end
	end

endmodule

@@ rtl/core/rrc_emit.sv @@
// ----------------------------------------------------------------------------
// rrc_emit
// Output stage: holds one item's pieces and sends them one beat per cycle while dn_ready is high.
// ----------------------------------------------------------------------------
module rrc_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  rrc_pkg::s3_t       up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output rrc_pkg::out_beat_t dn_data
);

	logic         busy_q;
	logic [1:0]   idx_q;
	rrc_pkg::s3_t item_q;
	logic         is_last;

	assign is_last  = idx_q == (item_q.cnt - 2'd1);
	assign up_ready = !busy_q || (dn_ready && is_last);
	assign dn_valid = busy_q;

	always_comb begin
		dn_data.relation         = item_q.rel;
		dn_data.piece_index      = idx_q;
		dn_data.piece_valid      = item_q.has_piece;
		dn_data.piece_low_upper  = item_q.pc[idx_q].lo[127:64];
		dn_data.piece_low_lower  = item_q.pc[idx_q].lo[63:0];
		dn_data.piece_high_upper = item_q.pc[idx_q].hi[127:64];
		dn_data.piece_high_lower = item_q.pc[idx_q].hi[63:0];
		dn_data.last             = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (up_valid && up_ready) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (busy_q && dn_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_q <= up_data;
		end
	end

endmodule

@@ rtl/core/ipv6_range_compare_and_cut_top.sv @@
// Path: an item is registered in the cmp, class and cut stages, then in the emit stage.
// Throughput: one item per cycle enters the three compute stages unless stalled; the
// output stage sends one beat per cycle while result_ready is high, 1 to 3 per item.
// Reset: arst_n clears all valid bits and the output stage's beat counter.
// ----------------------------------------------------------------------------
// ipv6_range_compare_and_cut_top
// Classifies two inclusive 128-bit ranges and cuts overlapping ones into pieces.
// ----------------------------------------------------------------------------
module ipv6_range_compare_and_cut_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rrc_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rrc_pkg::out_beat_t result
);

	logic         v1, r1, v2, r2, v3, r3;
	rrc_pkg::s1_t d1;
	rrc_pkg::s2_t d2;
	rrc_pkg::s3_t d3;

	rrc_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.up_data  (item),
		.dn_valid (v1),
		.dn_ready (r1),
		.dn_data  (d1)
	);

	rrc_class u_class (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v1),
		.up_ready (r1),
		.up_data  (d1),
		.dn_valid (v2),
		.dn_ready (r2),
		.dn_data  (d2)
	);

	rrc_cut u_cut (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v2),
		.up_ready (r2),
		.up_data  (d2),
		.dn_valid (v3),
		.dn_ready (r3),
		.dn_data  (d3)
	);

	rrc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v3),
		.up_ready (r3),
		.up_data  (d3),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_data  (result)
	);

	a_no_piece_single : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.piece_valid |-> result.last && result.piece_index == 2'd0)
		else $error("beat without a piece is not a lone last beat");

	a_index_steps : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last |=>
			result_valid && result.piece_index == $past(result.piece_index) + 2'd1)
		else $error("piece index did not advance by one within an item");

	a_piece_class : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.piece_valid |->
			result.relation == rrc_pkg::REL_INSIDE || result.relation == rrc_pkg::REL_ENCLOSES ||
			result.relation == rrc_pkg::REL_OVL_LOW || result.relation == rrc_pkg::REL_OVL_HIGH)
		else $error("piece emitted for a class that is not cut");

endmodule
